>>> hw/rtl/ssh_pkg.sv
// Shared constants for the sphere/segment hit test pipeline.
package ssh_pkg;

   // Default coordinate width and fraction bits of the fixed-point inputs.
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 4;

   // Number of register stages from request to response.
   localparam int NUM_STAGES = 6;

   // Number of spatial axes.
   localparam int NUM_AXES = 3;

endpackage

>>> hw/rtl/ssh_datapath.sv
// Arithmetic pipeline of the sphere/segment hit test, one register stage per enable bit.
module ssh_datapath
   import ssh_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic [NUM_STAGES-1:0]        adv,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic signed [COORD_BITS-1:0] center_z,
   input  logic [COORD_BITS-2:0]        radius,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] start_z,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic signed [COORD_BITS-1:0] end_z,
   output logic                         hit
);

   // Widths of the intermediate values.
   localparam int DW   = COORD_BITS + 1;              // coordinate difference
   localparam int PW   = 2 * DW;                      // product of two differences
   localparam int SQW  = 2 * COORD_BITS + 1;          // square of a difference
   localparam int NW   = 2 * COORD_BITS + 2;          // sum of three squares
   localparam int NNW  = 2 * COORD_BITS + 3;          // signed dot product
   localparam int KMW  = 2 * COORD_BITS + 2;          // cross product magnitude
   localparam int H    = (KMW + 1) / 2;               // low half of a magnitude
   localparam int HI   = KMW - H;                     // high half of a magnitude
   localparam int LW   = 2 * KMW;                     // square of a magnitude
   localparam int R2W  = 2 * (COORD_BITS - 1);        // radius squared
   localparam int RRW  = ((COORD_BITS - 1 > FRAC_BITS) ? COORD_BITS - 1 : FRAC_BITS) + 1;
   localparam int RR2W = 2 * RRW;                     // (radius + 1.0) squared
   localparam int DH   = (NW + 1) / 2;                // low half of D
   localparam int DHI  = NW - DH;                     // high half of D
   localparam int RW   = R2W + NW;                    // r*r*D
   localparam int CW   = (NW > RR2W) ? NW : RR2W;     // zero-length compare width
   localparam int SW   = (LW + 2 > RW) ? LW + 2 : RW; // final compare width

   // Signed product of two differences, kept at full width.
   function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return p;
   endfunction

   // Square of a difference; the value is never negative.
   function automatic logic [SQW-1:0] ssq(input logic signed [DW-1:0] a);
      logic signed [PW-1:0] p;
      p = smul(a, a);
      return p[SQW-1:0];
   endfunction

   // Per-axis views of the request.
   logic signed [COORD_BITS-1:0] c_ax [NUM_AXES];
   logic signed [COORD_BITS-1:0] s_ax [NUM_AXES];
   logic signed [COORD_BITS-1:0] e_ax [NUM_AXES];

   assign c_ax[0] = center_x;
   assign c_ax[1] = center_y;
   assign c_ax[2] = center_z;
   assign s_ax[0] = start_x;
   assign s_ax[1] = start_y;
   assign s_ax[2] = start_z;
   assign e_ax[0] = end_x;
   assign e_ax[1] = end_y;
   assign e_ax[2] = end_z;

   // Stage 1: differences d = E - S, w = C - S, f = C - E and the two radii.
   logic signed [DW-1:0] d_ff [NUM_AXES];
   logic signed [DW-1:0] w_ff [NUM_AXES];
   logic signed [DW-1:0] f_ff [NUM_AXES];
   logic [COORD_BITS-2:0] r1_ff;
   logic [RRW-1:0]        rr1_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            d_ff[a] <= DW'(e_ax[a]) - DW'(s_ax[a]);
            w_ff[a] <= DW'(c_ax[a]) - DW'(s_ax[a]);
            f_ff[a] <= DW'(c_ax[a]) - DW'(e_ax[a]);
         end
         r1_ff  <= radius;
         rr1_ff <= RRW'(radius) + (RRW'(1) << FRAC_BITS);
      end
   end

   // Stage 2: squares, dot terms, cross terms and squared radii.
   logic [SQW-1:0]       sqd_ff [NUM_AXES];
   logic [SQW-1:0]       sqw_ff [NUM_AXES];
   logic [SQW-1:0]       sqf_ff [NUM_AXES];
   logic signed [PW-1:0] dot_ff [NUM_AXES];
   logic signed [PW-1:0] cra_ff [NUM_AXES];
   logic signed [PW-1:0] crb_ff [NUM_AXES];
   logic [R2W-1:0]       r2a_ff;
   logic [RR2W-1:0]      rr2a_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            sqd_ff[a] <= ssq(d_ff[a]);
            sqw_ff[a] <= ssq(w_ff[a]);
            sqf_ff[a] <= ssq(f_ff[a]);
            dot_ff[a] <= smul(w_ff[a], d_ff[a]);
            cra_ff[a] <= smul(w_ff[(a + 1) % NUM_AXES], d_ff[(a + 2) % NUM_AXES]);
            crb_ff[a] <= smul(w_ff[(a + 2) % NUM_AXES], d_ff[(a + 1) % NUM_AXES]);
         end
         r2a_ff  <= R2W'(r1_ff) * R2W'(r1_ff);
         rr2a_ff <= RR2W'(rr1_ff) * RR2W'(rr1_ff);
      end
   end

   // Stage 3: D = d.d, n = w.d, |w|^2, |f|^2 and cross product magnitudes.
   logic [NW-1:0]         dd_ff;
   logic signed [NNW-1:0] n_ff;
   logic [NW-1:0]         ws_ff;
   logic [NW-1:0]         es_ff;
   logic [KMW-1:0]        km_ff [NUM_AXES];
   logic [R2W-1:0]        r2b_ff;
   logic [RR2W-1:0]       rr2b_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         dd_ff <= NW'(sqd_ff[0]) + NW'(sqd_ff[1]) + NW'(sqd_ff[2]);
         n_ff  <= NNW'(dot_ff[0]) + NNW'(dot_ff[1]) + NNW'(dot_ff[2]);
         ws_ff <= NW'(sqw_ff[0]) + NW'(sqw_ff[1]) + NW'(sqw_ff[2]);
         es_ff <= NW'(sqf_ff[0]) + NW'(sqf_ff[1]) + NW'(sqf_ff[2]);
         for (int a = 0; a < NUM_AXES; a++) begin
            km_ff[a] <= (cra_ff[a] >= crb_ff[a]) ? KMW'(cra_ff[a] - crb_ff[a])
                                                 : KMW'(crb_ff[a] - cra_ff[a]);
         end
         r2b_ff  <= r2a_ff;
         rr2b_ff <= rr2a_ff;
      end
   end

   // Stage 4: case flags, endpoint tests and half-width partial products.
   logic [2*H-1:0]    pll_ff [NUM_AXES];
   logic [H+HI-1:0]   plh_ff [NUM_AXES];
   logic [2*HI-1:0]   phh_ff [NUM_AXES];
   logic [R2W+DH-1:0] rdl_ff;
   logic [R2W+DHI-1:0] rdh_ff;
   logic              dzero4_ff;
   logic              inseg4_ff;
   logic              ephit4_ff;
   logic              zhit4_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            pll_ff[a] <= (2*H)'(km_ff[a][H-1:0]) * (2*H)'(km_ff[a][H-1:0]);
            plh_ff[a] <= (H+HI)'(km_ff[a][H-1:0]) * (H+HI)'(km_ff[a][KMW-1:H]);
            phh_ff[a] <= (2*HI)'(km_ff[a][KMW-1:H]) * (2*HI)'(km_ff[a][KMW-1:H]);
         end
         rdl_ff    <= (R2W+DH)'(r2b_ff) * (R2W+DH)'(dd_ff[DH-1:0]);
         rdh_ff    <= (R2W+DHI)'(r2b_ff) * (R2W+DHI)'(dd_ff[NW-1:DH]);
         dzero4_ff <= (dd_ff == '0);
         inseg4_ff <= !n_ff[NNW-1] && (n_ff[NNW-2:0] <= dd_ff);
         ephit4_ff <= (ws_ff <= NW'(r2b_ff)) || (es_ff <= NW'(r2b_ff));
         zhit4_ff  <= (CW'(ws_ff) <= CW'(rr2b_ff));
      end
   end

   // Stage 5: squared cross product components and r*r*D.
   logic [LW-1:0] ksq_ff [NUM_AXES];
   logic [RW-1:0] rhs_ff;
   logic          dzero5_ff;
   logic          inseg5_ff;
   logic          ephit5_ff;
   logic          zhit5_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            ksq_ff[a] <= (LW'(phh_ff[a]) << (2 * H)) + (LW'(plh_ff[a]) << (H + 1))
                         + LW'(pll_ff[a]);
         end
         rhs_ff    <= (RW'(rdh_ff) << DH) + RW'(rdl_ff);
         dzero5_ff <= dzero4_ff;
         inseg5_ff <= inseg4_ff;
         ephit5_ff <= ephit4_ff;
         zhit5_ff  <= zhit4_ff;
      end
   end

   // Stage 6: line distance compare and choice of the case that applies.
   logic [SW-1:0] lhs_sum;
   logic          line_hit;

   assign lhs_sum  = SW'(ksq_ff[0]) + SW'(ksq_ff[1]) + SW'(ksq_ff[2]);
   assign line_hit = (lhs_sum <= SW'(rhs_ff));

   logic hit_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         hit_ff <= dzero5_ff ? zhit5_ff : (inseg5_ff ? line_hit : ephit5_ff);
      end
   end

   assign hit = hit_ff;

endmodule

>>> hw/rtl/sphere_segment_hit_test.sv
// Top level of the sphere/segment hit test: handshake control around the arithmetic pipeline.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  center, radius, start, end
//   rsp_      out        rsp_valid / rsp_stall  hit
//
// One request enters per cycle while req_stall is low; each response passes through
// the six register stages of the arithmetic pipeline.
// Reset clears only the stage valid bits; no result survives it.
// A stalled response holds the last stage, and earlier stages keep moving
// until they fill, so empty stages are squeezed out before req_stall rises.
module sphere_segment_hit_test
   import ssh_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic signed [COORD_BITS-1:0] req_center_z,
   input  logic [COORD_BITS-2:0]        req_radius,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit
);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] adv;

   // A stage may load when it is empty or when the stage after it loads.
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   // Valid bits move along with the data they describe.
   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // Arithmetic pipeline.
   ssh_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .adv      (adv),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .center_z (req_center_z),
      .radius   (req_radius),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .start_z  (req_start_z),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .end_z    (req_end_z),
      .hit      (rsp_hit)
   );

   // The input side stalls only when every stage holds a request.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> (&vld_ff))
      else $error("request stalled while the pipeline has an empty stage");

   // With no response waiting, the pipeline always takes a new request.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output stage");

   // A request in the second to last stage that moves on becomes a response.
   assert property (@(posedge clock) disable iff (reset)
                    (vld_ff[NUM_STAGES-2] && adv[NUM_STAGES-1]) |=> rsp_valid)
      else $error("request lost between the last two stages");

endmodule

>>> test/sphere_segment_hit_test_tb.sv
// Self-checking testbench for the sphere/segment hit test with a scoreboard and random stalls.
module sphere_segment_hit_test_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssh_pkg::*;

   localparam int CB           = COORD_BITS_DEF;
   localparam int RANDOM_ITEMS = 930;
   localparam int TAIL_ITEMS   = 100;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_MAX   = 10;

   // Wide enough for every product of the exact test without overflow.
   typedef logic signed [127:0] acc_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][CB-1:0] center;
      logic [CB-2:0]               radius;
      logic [NUM_AXES-1:0][CB-1:0] start;
      logic [NUM_AXES-1:0][CB-1:0] stop;
   } sphere_query_type;

   // Holds the predicted hit flags of accepted requests in order.
   class hit_scoreboard_type;
      bit expected_hits [$];
      int request_ids [$];
      int failures;
      int next_id;

      function new();
         failures = 0;
         next_id  = 0;
      endfunction

      // Exact sphere/segment contact test on wide signed integers.
      function bit predict_hit(sphere_query_type q);
         acc_type c [NUM_AXES];
         acc_type s [NUM_AXES];
         acc_type e [NUM_AXES];
         acc_type d [NUM_AXES];
         acc_type w [NUM_AXES];
         acc_type rad, len2, along, to_start2, to_end2, reach;
         acc_type kx, ky, kz, cross2;
         rad       = acc_type'(q.radius);
         len2      = 0;
         along     = 0;
         to_start2 = 0;
         to_end2   = 0;
         for (int i = 0; i < NUM_AXES; i++) begin
            c[i] = acc_type'($signed(q.center[i]));
            s[i] = acc_type'($signed(q.start[i]));
            e[i] = acc_type'($signed(q.stop[i]));
            d[i] = e[i] - s[i];
            w[i] = c[i] - s[i];
            len2      += d[i] * d[i];
            along     += w[i] * d[i];
            to_start2 += w[i] * w[i];
            to_end2   += (c[i] - e[i]) * (c[i] - e[i]);
         end
         // A zero-length segment is tested against a radius grown by one unit.
         if (len2 == 0) begin
            reach = rad + (1 << FRAC_BITS_DEF);
            return to_start2 <= reach * reach;
         end
         // Closest point inside the segment: compare |w x d|^2 with r^2 * |d|^2.
         if (along >= 0 && along <= len2) begin
            kx = w[1] * d[2] - w[2] * d[1];
            ky = w[2] * d[0] - w[0] * d[2];
            kz = w[0] * d[1] - w[1] * d[0];
            cross2 = kx * kx + ky * ky + kz * kz;
            return cross2 <= rad * rad * len2;
         end
         // Otherwise the nearer endpoint decides.
         return (to_start2 <= rad * rad) || (to_end2 <= rad * rad);
      endfunction

      function void note_request(sphere_query_type q);
         expected_hits.push_back(predict_hit(q));
         request_ids.push_back(next_id);
         next_id++;
      endfunction

      function void check_response(logic actual);
         bit want;
         int id;
         if (expected_hits.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected response: hit %0b with no request outstanding", actual);
            return;
         end
         want = expected_hits.pop_front();
         id   = request_ids.pop_front();
         if (actual !== want) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("mismatch on request %0d: hit expected %0b actual %0b", id, want, actual);
         end
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [CB-1:0] req_center_x = '0;
   logic signed [CB-1:0] req_center_y = '0;
   logic signed [CB-1:0] req_center_z = '0;
   logic [CB-2:0]        req_radius = '0;
   logic signed [CB-1:0] req_start_x = '0;
   logic signed [CB-1:0] req_start_y = '0;
   logic signed [CB-1:0] req_start_z = '0;
   logic signed [CB-1:0] req_end_x = '0;
   logic signed [CB-1:0] req_end_y = '0;
   logic signed [CB-1:0] req_end_z = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_hit;

   hit_scoreboard_type board;
   int requests_sent = 0;
   bit in_tail = 1'b0;

   sphere_segment_hit_test dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_start_z  (req_start_z),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .req_end_z    (req_end_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic sphere_query_type make_query(int cx, int cy, int cz, int r,
                                                   int sx, int sy, int sz,
                                                   int ex, int ey, int ez);
      sphere_query_type q;
      q.center[0] = cx[CB-1:0];
      q.center[1] = cy[CB-1:0];
      q.center[2] = cz[CB-1:0];
      q.radius    = r[CB-2:0];
      q.start[0]  = sx[CB-1:0];
      q.start[1]  = sy[CB-1:0];
      q.start[2]  = sz[CB-1:0];
      q.stop[0]   = ex[CB-1:0];
      q.stop[1]   = ey[CB-1:0];
      q.stop[2]   = ez[CB-1:0];
      return q;
   endfunction

   // Signed value in [-2^span, 2^span - 1], wrapped to the coordinate width.
   function automatic logic [CB-1:0] rand_coord(int span);
      int lim;
      int v;
      lim = 1 << span;
      v   = int'($urandom_range(0, 2 * lim - 1)) - lim;
      return v[CB-1:0];
   endfunction

   // Random request: mostly scenes scaled so that hits and misses both occur.
   function automatic sphere_query_type make_random_query();
      sphere_query_type q;
      int kind;
      int span;
      int r;
      int off;
      logic [5*32-1:0] raw;
      logic [CB-1:0] shift;
      kind  = $urandom_range(0, 9);
      span  = $urandom_range(2, 14);
      shift = rand_coord(13);
      r     = $urandom_range(0, (1 << span) - 1);
      q.radius = r[CB-2:0];
      for (int i = 0; i < NUM_AXES; i++) begin
         q.start[i]  = rand_coord(span) + shift;
         q.stop[i]   = rand_coord(span) + shift;
         q.center[i] = rand_coord(span) + shift;
      end
      case (kind)
         0, 1: begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            q   = raw[$bits(sphere_query_type)-1:0];
         end
         7: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               q.stop[i]   = q.start[i];
               q.center[i] = q.start[i] + rand_coord(span);
            end
         end
         8: begin
            r = $urandom_range(0, 3);
            q.radius = r[CB-2:0];
            for (int i = 0; i < NUM_AXES; i++)
               q.center[i] = ($urandom_range(0, 1) != 0) ? q.start[i] : q.stop[i];
         end
         9: begin
            // Zero-length segment with the centre on or next to the grown-radius boundary.
            r = $urandom_range(0, 4000);
            q.radius = r[CB-2:0];
            for (int i = 0; i < NUM_AXES; i++) begin
               q.stop[i]   = q.start[i];
               q.center[i] = q.start[i];
            end
            off = r + (1 << FRAC_BITS_DEF) + int'($urandom_range(0, 2)) - 1;
            q.center[0] = q.start[0] + off[CB-1:0];
         end
         default: begin
         end
      endcase
      return q;
   endfunction

   // Offers one request after an optional gap and waits for it to be taken.
   task automatic send_query(sphere_query_type q, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_center_x <= q.center[0];
      req_center_y <= q.center[1];
      req_center_z <= q.center[2];
      req_radius   <= q.radius;
      req_start_x  <= q.start[0];
      req_start_y  <= q.start[1];
      req_start_z  <= q.start[2];
      req_end_x    <= q.stop[0];
      req_end_y    <= q.stop[1];
      req_end_z    <= q.stop[2];
      req_valid    <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      requests_sent++;
   endtask

   // Response side: check accepted responses and stall in random bursts.
   int hold_left = 0;
   int stall_pct = 10;
   int phase_cycles = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_hit);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         phase_cycles++;
         if (phase_cycles == 128) begin
            phase_cycles = 0;
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 35;
            endcase
         end
         if (hold_left != 0)
            hold_left--;
         else if (!in_tail && $urandom_range(0, 99) < stall_pct)
            hold_left = $urandom_range(1, 12);
         // One long hold-off so the pipeline fills and pushes back on requests.
         if (!long_hold_done && requests_sent >= 300) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("sphere_segment_hit_test regression: fail");
         $finish;
      end
   end

   initial begin
      int gap;
      int gap_pct;
      gap_pct = 0;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: boundaries, extremes and each branch of the test.
      send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_query(make_query(48, 0, 0, 32, 0, 0, 0, 0, 0, 0), 0);
      send_query(make_query(49, 0, 0, 32, 0, 0, 0, 0, 0, 0), 0);
      send_query(make_query(80, 48, 0, 48, 0, 0, 0, 160, 0, 0), 0);
      send_query(make_query(80, 48, 0, 47, 0, 0, 0, 160, 0, 0), 0);
      send_query(make_query(0, 50, 0, 50, 0, 0, 0, 100, 0, 0), 0);
      send_query(make_query(100, -30, 0, 30, 0, 0, 0, 100, 0, 0), 0);
      send_query(make_query(-40, 0, 0, 40, 0, 0, 0, 100, 0, 0), 0);
      send_query(make_query(-40, 0, 0, 39, 0, 0, 0, 100, 0, 0), 0);
      send_query(make_query(140, 0, 0, 40, 0, 0, 0, 100, 0, 0), 0);
      send_query(make_query(32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, 32767, 32767, 32767), 0);
      send_query(make_query(-32768, -32768, -32768, 0,
                            32767, 32767, 32767, -32768, -32768, -32768), 0);
      send_query(make_query(32767, -32768, 32767, 32767,
                            -32768, 32767, -32768, 32767, -32768, 32767), 0);
      send_query(make_query(-32768, -32768, -32768, 32767,
                            32767, 32767, 32767, 32767, 32767, 32767), 0);
      send_query(make_query(0, 0, 0, 32767,
                            -32768, -32768, -32768, 32767, 32767, 32767), 0);
      send_query(make_query(10, 20, 30, 5, -7, 3, 11, 200, -150, 90), 0);
      send_query(make_query(5, 6, 7, 0, 5, 6, 7, 50, 60, 70), 0);
      send_query(make_query(-100, -100, -100, 0, -100, -100, -84, -100, -100, -84), 0);
      send_query(make_query(0, 0, 1000, 10, 0, 0, 0, 0, 0, 500), 0);
      send_query(make_query(0, 100, 0, 100, 200, 0, 0, -200, 0, 0), 0);

      // Random requests with changing gap density and a quiet tail.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 10;
               default: gap_pct = 30;
            endcase
         end
         if (i >= RANDOM_ITEMS - TAIL_ITEMS)
            in_tail = 1'b1;
         gap = (!in_tail && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
         send_query(make_random_query(), gap);
      end
      req_valid <= 1'b0;

      // Drain, then give stray responses a chance to show up.
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4 * NUM_STAGES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("sphere_segment_hit_test regression: pass");
      else
         $display("sphere_segment_hit_test regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ssh_pkg.sv
hw/rtl/ssh_datapath.sv
hw/rtl/sphere_segment_hit_test.sv
test/sphere_segment_hit_test_tb.sv
